/* rtl/core/sitda_pkg.sv */
package sitda_pkg;

	localparam int ValueWidth = 32;
	localparam int BcdDigits  = 10;
	localparam int BcdWidth   = 4 * BcdDigits;
	localparam int CharWidth  = 8;
	localparam int BitCntWidth   = $clog2(ValueWidth + 1);
	localparam int DigitCntWidth = $clog2(BcdDigits + 1);

	localparam logic [CharWidth-1:0] CharZero  = 8'd48;
	localparam logic [CharWidth-1:0] CharMinus = 8'd45;

	// Control sequencer of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} ctrl_state_t;

	// Request from the sequencer to the character emitter.
	typedef struct packed {
		logic load;
		logic neg;
	} emit_ctrl_t;

	// Status returned by the converter and the emitter.
	typedef struct packed {
		logic conv_done;
		logic emit_busy;
	} core_status_t;

	// Add three to every BCD digit of five or more, ahead of the next shift.
	function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] bcd);
		logic [BcdWidth-1:0] res;
		logic [3:0]          dig;
		res = bcd;
		for (int i = 0; i < BcdDigits; i++) begin
			dig = bcd[4*i +: 4];
			if (dig >= 4'd5) begin
				res[4*i +: 4] = dig + 4'd3;
			end
		end
		return res;
	endfunction

endpackage

/* rtl/core/sitda_dabble.sv */
module sitda_dabble (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sitda_pkg::ValueWidth-1:0]   mag,
	output logic                               done,
	output logic [sitda_pkg::BcdWidth-1:0]     bcd
);
	import sitda_pkg::*;

	logic [ValueWidth-1:0]  bin_q;
	logic [BcdWidth-1:0]    bcd_q;
	logic [BcdWidth-1:0]    bcd_adj;
	logic [BitCntWidth-1:0] cnt_q;
	logic                   run_q;
	logic                   done_q;

	assign bcd_adj = bcd_adjust(bcd_q);

	// Control: count one binary bit per cycle, flag the end for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= BitCntWidth'(ValueWidth);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - BitCntWidth'(1);
				if (cnt_q == BitCntWidth'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the binary word into the BCD register, MSB first.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[ValueWidth-2:0], 1'b0};
			bcd_q <= {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

/* rtl/core/sitda_emit.sv */
module sitda_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sitda_pkg::emit_ctrl_t             ctrl,
	input  logic [sitda_pkg::BcdWidth-1:0]    bcd,
	output logic                              busy,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sitda_pkg::CharWidth-1:0]   m_tdata,
	output logic                              m_tlast
);
	import sitda_pkg::*;

	logic [BcdWidth-1:0]      dig_q;
	logic [DigitCntWidth-1:0] cnt_q;
	logic                     sign_q;
	logic                     lead_q;
	logic                     active_q;
	logic                     valid_q;
	logic [CharWidth-1:0]     char_q;
	logic                     last_q;
	logic [3:0]               top_dig;
	logic                     skip;
	logic                     slot_free;
	logic                     send;

	// Zeros are dropped only ahead of the first character of the text.
	assign top_dig   = dig_q[BcdWidth-1 -: 4];
	assign skip      = active_q && lead_q && (cnt_q > DigitCntWidth'(1)) &&
		(top_dig == 4'd0);
	assign slot_free = !valid_q || m_tready;
	assign send      = active_q && !skip && slot_free;

	// Control: drop leading zeros one digit a cycle, then send sign and digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sign_q   <= 1'b0;
			lead_q   <= 1'b0;
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			// The output is raised by a new character and dropped once taken.
			if (send) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			if (ctrl.load) begin
				cnt_q    <= DigitCntWidth'(BcdDigits);
				sign_q   <= ctrl.neg;
				lead_q   <= 1'b1;
				active_q <= 1'b1;
			end else if (skip) begin
				cnt_q <= cnt_q - DigitCntWidth'(1);
			end else if (send) begin
				lead_q <= 1'b0;
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - DigitCntWidth'(1);
					if (cnt_q == DigitCntWidth'(1)) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	// Datapath: digit shift register and the output register.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dig_q <= bcd;
		end else if (skip) begin
			dig_q <= {dig_q[BcdWidth-5:0], 4'd0};
		end else if (send) begin
			if (sign_q) begin
				char_q <= CharMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= CharZero + {4'd0, top_dig};
				last_q <= (cnt_q == DigitCntWidth'(1));
				dig_q  <= {dig_q[BcdWidth-5:0], 4'd0};
			end
		end
	end

	assign busy     = active_q || valid_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule

/* rtl/core/signed_int_to_decimal_ascii_core.sv */
// Signed 32-bit integer to decimal ASCII text.
// Input stream (s_*): one request per integer, two's complement in s_tdata.
// Output stream (m_*): the characters of each integer, most significant digit
// first, with a leading '-' for negative values; m_tlast marks the final
// character. Leading zeros are dropped, and zero gives the single character '0'.
// Sequence: the magnitude is converted by a bit-serial double dabble, and its
// registered done flag then loads the emitter. Leading zeros are dropped one
// per cycle (up to 9), and characters leave one per cycle from a single output
// register while m_tready is high. One integer is in flight at a
// time: s_tready is high only when the previous text has been fully delivered.
// When m_tready is low, the output register holds its character and the
// emitter waits; nothing is lost. Reset (arst_n low) clears the sequencer,
// the converter and the output valid, so any text in progress is dropped.
module signed_int_to_decimal_ascii_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sitda_pkg::ValueWidth-1:0]  s_tdata,  // [31:0] value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sitda_pkg::CharWidth-1:0]   m_tdata,  // [7:0] character
	output logic                              m_tlast
);
	import sitda_pkg::*;

	ctrl_state_t           state_q;
	ctrl_state_t           state_nxt;
	core_status_t          status;
	emit_ctrl_t            emit_ctrl;
	logic                  neg_q;
	logic                  accept;
	logic [ValueWidth-1:0] mag;
	logic [BcdWidth-1:0]   bcd;

	assign accept = s_tvalid && s_tready;
	assign mag    = s_tdata[ValueWidth-1] ? (ValueWidth'(0) - s_tdata) : s_tdata;

	// Next state of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (status.conv_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.emit_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		emit_ctrl.load = (state_q == ST_CONVERT) && status.conv_done;
		emit_ctrl.neg  = neg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sign of the value being converted.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= s_tdata[ValueWidth-1];
		end
	end

	sitda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.done   (status.conv_done),
		.bcd    (bcd)
	);

	sitda_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (emit_ctrl),
		.bcd      (bcd),
		.busy     (status.emit_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* rtl/core/sitda_checker.sv */
module sitda_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [sitda_pkg::ValueWidth-1:0]  s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sitda_pkg::CharWidth-1:0]   m_tdata,
	input logic                              m_tlast
);
	import sitda_pkg::*;

	// A stalled character stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output character changed or vanished");

	// A new integer is taken only once all earlier text has left.
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid && !s_tready)
		else $error("request accepted while output busy");

	// The minus sign never ends a run.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CharMinus) |-> !m_tlast)
		else $error("minus sign flagged as last character");

	// Every character is a minus sign or a decimal digit.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == CharMinus) ||
			((m_tdata >= CharZero) && (m_tdata <= CharZero + 8'd9)))
		else $error("character outside the decimal text set");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (.*);
